[sv/ircft_pkg.sv]
// Package for the IRC message field tagger: byte classes, parser states,
// tag and error codes, and the beat types passed between front and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ircft_pkg;

  localparam int unsigned MAX_PARAMS = 15;
  localparam int unsigned PC_W = $clog2(MAX_PARAMS + 1);
  localparam logic [2:0] MAX_DIGITS_RESET = 3'd3;
  localparam logic [2:0] DIGIT_CAP = 3'd7;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_PFX_FIRST = 4'd1,
    ST_NICK      = 4'd2,
    ST_USER      = 4'd3,
    ST_HOST      = 4'd4,
    ST_CMD_FIRST = 4'd5,
    ST_CMD       = 4'd6,
    ST_DIGITS    = 4'd7,
    ST_PSPACE    = 4'd8,
    ST_MIDDLE    = 4'd9,
    ST_TRAIL     = 4'd10,
    ST_CR        = 4'd11
  } parse_state_t;

  typedef enum logic [3:0] {
    TAG_DROP     = 4'd0,
    TAG_PREFIX   = 4'd1,
    TAG_USER     = 4'd2,
    TAG_HOST     = 4'd3,
    TAG_COMMAND  = 4'd4,
    TAG_DIGIT    = 4'd5,
    TAG_MIDDLE   = 4'd6,
    TAG_TRAILING = 4'd7,
    TAG_DELIM    = 4'd8,
    TAG_LINE_END = 4'd9
  } tag_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_PREFIX  = 3'd1,
    ERR_NO_CMD  = 3'd2,
    ERR_DIGITS  = 3'd3,
    ERR_NUL_END = 3'd4,
    ERR_ENDING  = 3'd5,
    ERR_PARAMS  = 3'd6
  } err_t;

  typedef struct packed {
    logic letter;
    logic digit;
    logic nick;
    logic space;
    logic colon;
    logic bang;
    logic at;
    logic nul;
    logic cr;
    logic lf;
  } char_class_t;

  typedef struct packed {
    logic [7:0]  data;
    char_class_t cls;
  } class_beat_t;

  typedef struct packed {
    logic [7:0] echo;
    tag_t       tag;
    logic       start;
    logic [3:0] pidx;
    err_t       err;
    logic       eom;
  } result_beat_t;

  function automatic char_class_t classify(input logic [7:0] b);
    char_class_t c;
    c.letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    c.digit  = (b >= 8'h30 && b <= 8'h39);
    // - [ ] \ ` ^ { }
    c.nick   = c.letter || c.digit || b == 8'h2D || b == 8'h5B || b == 8'h5D ||
               b == 8'h5C || b == 8'h60 || b == 8'h5E || b == 8'h7B || b == 8'h7D;
    c.space  = (b == CH_SPACE);
    c.colon  = (b == CH_COLON);
    c.bang   = (b == CH_BANG);
    c.at     = (b == CH_AT);
    c.nul    = (b == CH_NUL);
    c.cr     = (b == CH_CR);
    c.lf     = (b == CH_LF);
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/ircft_front.sv]
// Front end: accepts raw bytes, classifies them and holds them in a
// two-entry queue for the parser. Depends on ircft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ircft_front import ircft_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        push,
  output logic             full,
  output logic             beat_valid,
  output class_beat_t      beat,
  input  wire logic        beat_take
);

  class_beat_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign beat_valid = (count != 2'd0);
  assign beat       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = beat_take && beat_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{data: data_byte, cls: classify(data_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

[sv/ircft_back.sv]
// Back end: the message parser state machine and a two-entry result queue.
// Holds the max_digits register. Depends on ircft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ircft_back import ircft_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        beat_valid,
  input  wire class_beat_t beat,
  output logic             beat_take,
  output result_beat_t     res,
  output logic             empty,
  input  wire logic        pop
);

  logic [2:0]       max_digits;
  parse_state_t     state;
  parse_state_t     state_next;
  logic [2:0]       digit_count;
  logic [2:0]       digit_count_next;
  logic [PC_W-1:0]  param_count;
  logic [PC_W-1:0]  param_count_next;
  err_t             sticky_error;
  err_t             sticky_error_next;
  tag_t             prev_tag;

  tag_t         tag;
  err_t         raise;
  logic         eom;
  logic         do_param;
  logic         do_digit;
  logic         do_cmd_first;
  logic         do_nick_end;
  char_class_t  c;
  logic         cmd_seen;
  result_beat_t res_in;

  result_beat_t q [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_pop;

  assign do_pop    = pop && !empty;
  assign empty     = (count == 2'd0);
  assign res       = q[rd_ptr];
  assign beat_take = beat_valid && (count != 2'd2 || do_pop);
  assign c         = beat.cls;
  assign cmd_seen  = (state == ST_CMD) || (state == ST_DIGITS) || (state == ST_PSPACE) ||
                     (state == ST_MIDDLE) || (state == ST_TRAIL);

  // Flags defer the shared sub-steps so that the first error raised in a beat wins.
  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    param_count_next = param_count;
    tag              = TAG_DROP;
    raise            = ERR_NONE;
    eom              = 1'b0;
    do_param         = 1'b0;
    do_digit         = 1'b0;
    do_cmd_first     = 1'b0;
    do_nick_end      = 1'b0;

    if (state == ST_CR) begin
      tag = TAG_LINE_END;
      if (!c.lf) raise = ERR_ENDING;
      eom = 1'b1;
    end else if (c.nul || c.cr || c.lf) begin
      tag = TAG_LINE_END;
      if (!cmd_seen) raise = ERR_NO_CMD;
      if (c.nul) begin
        if (raise == ERR_NONE) raise = ERR_NUL_END;
        eom = 1'b1;
      end else if (c.lf) begin
        if (raise == ERR_NONE) raise = ERR_ENDING;
        eom = 1'b1;
      end else begin
        state_next = ST_CR;
      end
    end else begin
      case (state)
        ST_PFX_FIRST: begin
          if (c.letter) begin
            state_next = ST_NICK;
            tag = TAG_PREFIX;
          end else begin
            raise = ERR_PREFIX;
            do_nick_end = 1'b1;
          end
        end
        ST_NICK: begin
          if (c.nick) tag = TAG_PREFIX;
          else do_nick_end = 1'b1;
        end
        ST_USER: begin
          if (c.at) begin
            state_next = ST_HOST;
            tag = TAG_DELIM;
          end else if (c.space) begin
            state_next = ST_CMD_FIRST;
          end else begin
            tag = TAG_USER;
          end
        end
        ST_HOST: begin
          if (c.space) state_next = ST_CMD_FIRST;
          else tag = TAG_HOST;
        end
        ST_CMD_FIRST: do_cmd_first = 1'b1;
        ST_CMD: begin
          if (c.letter) tag = TAG_COMMAND;
          else if (c.digit) do_digit = 1'b1;
          else do_param = 1'b1;
        end
        ST_DIGITS: begin
          if (c.digit) do_digit = 1'b1;
          else do_param = 1'b1;
        end
        ST_PSPACE: do_param = 1'b1;
        ST_MIDDLE: begin
          if (c.space) state_next = ST_PSPACE;
          else tag = TAG_MIDDLE;
        end
        ST_TRAIL: tag = TAG_TRAILING;
        default: begin
          if (c.colon) begin
            state_next = ST_PFX_FIRST;
            tag = TAG_DELIM;
          end else begin
            do_cmd_first = 1'b1;
          end
        end
      endcase
    end

    if (do_cmd_first) begin
      if (c.letter) begin
        state_next = ST_CMD;
        tag = TAG_COMMAND;
      end else if (c.digit) begin
        do_digit = 1'b1;
      end else begin
        if (raise == ERR_NONE) raise = ERR_NO_CMD;
        do_param = 1'b1;
      end
    end

    if (do_nick_end) begin
      if (c.bang) begin
        state_next = ST_USER;
        tag = TAG_DELIM;
      end else if (c.at) begin
        state_next = ST_HOST;
        tag = TAG_DELIM;
      end else begin
        if (!c.space && raise == ERR_NONE) raise = ERR_PREFIX;
        state_next = ST_CMD_FIRST;
        tag = TAG_DROP;
      end
    end

    if (do_digit) begin
      if (digit_count >= max_digits) begin
        if (raise == ERR_NONE) raise = ERR_DIGITS;
      end else if (digit_count < DIGIT_CAP) begin
        digit_count_next = digit_count + 3'd1;
      end
      state_next = ST_DIGITS;
      tag = TAG_DIGIT;
    end

    if (do_param) begin
      if (c.space) begin
        state_next = ST_PSPACE;
        tag = TAG_DROP;
      end else begin
        if (param_count < PC_W'(MAX_PARAMS)) param_count_next = param_count + PC_W'(1);
        else if (raise == ERR_NONE) raise = ERR_PARAMS;
        if (c.colon) begin
          state_next = ST_TRAIL;
          tag = TAG_DELIM;
        end else begin
          state_next = ST_MIDDLE;
          tag = TAG_MIDDLE;
        end
      end
    end

    sticky_error_next = (sticky_error != ERR_NONE) ? sticky_error : raise;

    res_in.echo  = beat.data;
    res_in.tag   = tag;
    res_in.start = (tag >= TAG_PREFIX) && (tag <= TAG_TRAILING) && (tag != prev_tag);
    res_in.pidx  = (param_count_next == '0) ? 4'd0 : 4'(param_count_next - PC_W'(1));
    res_in.err   = sticky_error_next;
    res_in.eom   = eom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= MAX_DIGITS_RESET;
    end else if (cfg_wr) begin
      max_digits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      digit_count  <= 3'd0;
      param_count  <= '0;
      sticky_error <= ERR_NONE;
      prev_tag     <= TAG_DROP;
    end else if (beat_take) begin
      if (eom) begin
        state        <= ST_START;
        digit_count  <= 3'd0;
        param_count  <= '0;
        sticky_error <= ERR_NONE;
        prev_tag     <= TAG_DROP;
      end else begin
        state        <= state_next;
        digit_count  <= digit_count_next;
        param_count  <= param_count_next;
        sticky_error <= sticky_error_next;
        prev_tag     <= tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take) begin
      q[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (beat_take) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, beat_take} - {1'b0, do_pop};
    end
  end

  // an ending beat always returns the parser to the start of a message
  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    beat_take && eom |=> state == ST_START && sticky_error == ERR_NONE && param_count == '0)
    else $error("parser not cleared after end of message");

  // a recorded error is held until the message ends
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    beat_take && !eom && sticky_error != ERR_NONE |=> sticky_error == $past(sticky_error))
    else $error("sticky error changed within a message");

  // result queue never overflows
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !do_pop |-> !beat_take)
    else $error("result queue overflow");

  // the parser only leaves the line-end wait on a taken beat that ends the message
  a_cr_ends: assert property (@(posedge clk) disable iff (rst)
    beat_take && state == ST_CR |-> eom)
    else $error("beat after CR did not end the message");

endmodule

`default_nettype wire

[sv/irc_message_field_tagger_top.sv]
// IRC message field tagger: one byte in, one tagged result out.
// Path: the front classifier queues each accepted byte; the back parser tags it into its queue.
// Throughput: one byte per cycle while full stays low; front and back each hold two beats.
// Reset (rst, synchronous): empties both queues, parser at start of message, max_digits = 3.
// Depends on ircft_pkg, ircft_front, ircft_back.
`timescale 1ns / 1ps
`default_nettype none

module irc_message_field_tagger_top import ircft_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr,
  input  wire logic [2:0]  cfg_data,
  input  wire logic [7:0]  data_byte,
  input  wire logic        push,
  output logic             full,
  output logic [7:0]       echo_byte,
  output logic [3:0]       field_tag,
  output logic             field_start,
  output logic [3:0]       param_index,
  output logic [2:0]       error_code,
  output logic             end_of_message,
  output logic             empty,
  input  wire logic        pop
);

  logic         beat_valid;
  logic         beat_take;
  class_beat_t  beat;
  result_beat_t res;

  ircft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .push       (push),
    .full       (full),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  ircft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res        (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign echo_byte      = res.echo;
  assign field_tag      = res.tag;
  assign field_start    = res.start;
  assign param_index    = res.pidx;
  assign error_code     = res.err;
  assign end_of_message = res.eom;

endmodule

`default_nettype wire

[tb/tb_irc_message_field_tagger_top.sv]
// Testbench for irc_message_field_tagger_top: random and directed IRC byte streams,
// each result checked against an in-bench tagging model of the parser.
// Depends on ircft_pkg and the tagger RTL.
`timescale 1ns / 1ps

module tb_irc_message_field_tagger_top;
  import ircft_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam string NICK_SET = "-[]\\\140^{}";

  typedef struct {
    bit         is_cfg;
    logic [7:0] value;
    int         phase;
  } feed_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr = 1'b0;
  logic [2:0] cfg_data = '0;
  logic [7:0] data_byte = '0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] echo_byte;
  logic [3:0] field_tag;
  logic       field_start;
  logic [3:0] param_index;
  logic [2:0] error_code;
  logic       end_of_message;
  logic       empty;
  logic       pop = 1'b0;

  irc_message_field_tagger_top DUT (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_wr), .cfg_data(cfg_data),
    .data_byte(data_byte), .push(push), .full(full),
    .echo_byte(echo_byte), .field_tag(field_tag), .field_start(field_start),
    .param_index(param_index), .error_code(error_code),
    .end_of_message(end_of_message), .empty(empty), .pop(pop)
  );

  // idle percentages per phase: sender, receiver
  int send_idle[3] = '{24, 56, 0};
  int recv_stall[3] = '{56, 24, 0};
  int pop_stall_pct = 56;

  feed_item_t   byte_feed[$];
  result_beat_t tag_q[$];
  int           fill_phase = 0;
  int           n_bytes = 0;
  int           n_bad = 0;
  int           quiet_cycles = 0;
  int           cycles = 0;

  // parser model state
  parse_state_t         ps = ST_START;
  logic [2:0]           dig_cnt = '0;
  logic [PC_W-1:0]      prm_cnt = '0;
  err_t                 err_q = ERR_NONE;
  tag_t                 last_tag = TAG_DROP;
  logic [2:0]           dig_limit = MAX_DIGITS_RESET;

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_nick(input logic [7:0] b);
    bit hit;
    hit = is_alpha(b) || is_num(b);
    for (int i = 0; i < NICK_SET.len(); i++)
      if (b == NICK_SET[i]) hit = 1'b1;
    return hit;
  endfunction

  function automatic void note_err(input err_t e);
    if (err_q == ERR_NONE) err_q = e;
  endfunction

  function automatic tag_t param_tag(input logic [7:0] b);
    if (b == CH_SPACE) begin
      ps = ST_PSPACE;
      return TAG_DROP;
    end
    if (prm_cnt < MAX_PARAMS) prm_cnt++;
    else note_err(ERR_PARAMS);
    if (b == CH_COLON) begin
      ps = ST_TRAIL;
      return TAG_DELIM;
    end
    ps = ST_MIDDLE;
    return TAG_MIDDLE;
  endfunction

  function automatic tag_t digit_tag();
    if (dig_cnt >= dig_limit) note_err(ERR_DIGITS);
    else if (dig_cnt < DIGIT_CAP) dig_cnt++;
    ps = ST_DIGITS;
    return TAG_DIGIT;
  endfunction

  function automatic tag_t command_tag(input logic [7:0] b);
    if (is_alpha(b)) begin
      ps = ST_CMD;
      return TAG_COMMAND;
    end
    if (is_num(b)) return digit_tag();
    note_err(ERR_NO_CMD);
    return param_tag(b);
  endfunction

  function automatic tag_t prefix_end(input logic [7:0] b);
    if (b == CH_BANG) begin
      ps = ST_USER;
      return TAG_DELIM;
    end
    if (b == CH_AT) begin
      ps = ST_HOST;
      return TAG_DELIM;
    end
    if (b != CH_SPACE) note_err(ERR_PREFIX);
    ps = ST_CMD_FIRST;
    return TAG_DROP;
  endfunction

  function automatic result_beat_t tag_next_byte(input logic [7:0] b);
    result_beat_t r;
    tag_t t;
    logic eom;
    t = TAG_DROP;
    eom = 1'b0;
    if (ps == ST_CR) begin
      // byte after CR always closes the line
      t = TAG_LINE_END;
      if (b != CH_LF) note_err(ERR_ENDING);
      eom = 1'b1;
    end else if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
      t = TAG_LINE_END;
      if (!(ps inside {ST_CMD, ST_DIGITS, ST_PSPACE, ST_MIDDLE, ST_TRAIL}))
        note_err(ERR_NO_CMD);
      if (b == CH_NUL) begin
        note_err(ERR_NUL_END);
        eom = 1'b1;
      end else if (b == CH_LF) begin
        note_err(ERR_ENDING);
        eom = 1'b1;
      end else begin
        ps = ST_CR;
      end
    end else begin
      case (ps)
        ST_PFX_FIRST: begin
          if (is_alpha(b)) begin
            ps = ST_NICK;
            t = TAG_PREFIX;
          end else begin
            note_err(ERR_PREFIX);
            t = prefix_end(b);
          end
        end
        ST_NICK: t = is_nick(b) ? TAG_PREFIX : prefix_end(b);
        ST_USER: begin
          if (b == CH_AT) begin
            ps = ST_HOST;
            t = TAG_DELIM;
          end else if (b == CH_SPACE) begin
            ps = ST_CMD_FIRST;
          end else begin
            t = TAG_USER;
          end
        end
        ST_HOST: begin
          if (b == CH_SPACE) ps = ST_CMD_FIRST;
          else t = TAG_HOST;
        end
        ST_CMD_FIRST: t = command_tag(b);
        ST_CMD: begin
          if (is_alpha(b)) t = TAG_COMMAND;
          else if (is_num(b)) t = digit_tag();
          else t = param_tag(b);
        end
        ST_DIGITS: t = is_num(b) ? digit_tag() : param_tag(b);
        ST_PSPACE: t = param_tag(b);
        ST_MIDDLE: begin
          if (b == CH_SPACE) ps = ST_PSPACE;
          else t = TAG_MIDDLE;
        end
        ST_TRAIL: t = TAG_TRAILING;
        default: begin
          if (b == CH_COLON) begin
            ps = ST_PFX_FIRST;
            t = TAG_DELIM;
          end else begin
            t = command_tag(b);
          end
        end
      endcase
    end
    r.echo = b;
    r.tag = t;
    r.start = (t >= TAG_PREFIX && t <= TAG_TRAILING && t != last_tag);
    r.pidx = (prm_cnt == '0) ? 4'd0 : 4'(prm_cnt - 1'b1);
    r.err = err_q;
    r.eom = eom;
    last_tag = t;
    if (eom) begin
      ps = ST_START;
      dig_cnt = '0;
      prm_cnt = '0;
      err_q = ERR_NONE;
      last_tag = TAG_DROP;
    end
    return r;
  endfunction

  // ---------------- stimulus builders ----------------
  task automatic put(input logic [7:0] b);
    byte_feed.insert(byte_feed.size(), '{1'b0, b, fill_phase});
    n_bytes++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_cfg(input logic [2:0] v);
    byte_feed.insert(byte_feed.size(), '{1'b1, {5'd0, v}, fill_phase});
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_text(input bit allow_space);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_CR || b == CH_LF || (!allow_space && b == CH_SPACE));
    return b;
  endfunction

  function automatic logic [7:0] rand_nick();
    case ($urandom_range(11))
      0: return rand_text(1'b0);
      1, 2: return 8'($urandom_range(48, 57));
      3, 4: return NICK_SET[$urandom_range(NICK_SET.len() - 1)];
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(13))
      0: return CH_COLON;
      1: return CH_BANG;
      2: return CH_AT;
      3: return CH_SPACE;
      4: return CH_CR;
      5: return CH_LF;
      6: return CH_NUL;
      7: return 8'($urandom_range(48, 57));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_ending();
    case ($urandom_range(9))
      0: put(CH_LF);
      1: put(CH_NUL);
      2: begin
        put(CH_CR);
        put(noisy_byte());
      end
      default: begin
        put(CH_CR);
        put(CH_LF);
      end
    endcase
  endtask

  task automatic put_message();
    int n_par;
    if ($urandom_range(1)) begin
      put(CH_COLON);
      put(($urandom_range(9) == 0) ? rand_text(1'b0) : rand_letter());
      repeat ($urandom_range(5)) put(rand_nick());
      if ($urandom_range(1)) begin
        put(CH_BANG);
        repeat ($urandom_range(1, 4)) put(rand_text(1'b0));
      end
      if ($urandom_range(1)) begin
        put(CH_AT);
        repeat ($urandom_range(1, 5)) put(rand_text(1'b0));
      end
      put(CH_SPACE);
    end
    case ($urandom_range(9))
      0: put(rand_text(1'b0));  // random text byte, not always a valid command
      1, 2: repeat ($urandom_range(1, 8)) put(8'($urandom_range(48, 57)));
      3, 4: begin
        repeat ($urandom_range(1, 3)) put(rand_letter());
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(48, 57)));
      end
      default: repeat ($urandom_range(1, 6)) put(rand_letter());
    endcase
    n_par = ($urandom_range(15) == 0) ? $urandom_range(14, 18) : $urandom_range(4);
    for (int i = 0; i < n_par; i++) begin
      repeat ($urandom_range(1, 2)) put(CH_SPACE);
      if (i == n_par - 1 && $urandom_range(1)) begin
        put(CH_COLON);
        repeat ($urandom_range(8)) put(rand_text(1'b1));
      end else begin
        repeat ($urandom_range(1, 5)) put(rand_text(1'b0));
      end
    end
    put_ending();
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 16)) put(noisy_byte());
    if ($urandom_range(1)) put_ending();
  endtask

  task automatic fill_random(input int upto);
    while (n_bytes < upto) begin
      if ($urandom_range(99) < 85) put_message();
      else put_noise();
    end
  endtask

  task automatic note_failure(input string msg);
    if (n_bad < 10) $display("%s", msg);
    n_bad++;
  endtask

  // ---------------- clock, stimulus, end of run ----------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    // directed: prefix with user and host, digit overflow at the reset limit,
    // middle and trailing params, lone LF, CR followed by a non-LF byte,
    // bad prefix start with 0xFF, NUL end
    put_str(":a!u@h P1234 m :t x");
    put(CH_CR);
    put(CH_LF);
    put(CH_LF);
    put(CH_CR);
    put("z");
    put(CH_COLON);
    put(8'hFF);
    put(CH_NUL);

    put_cfg(3'd1);
    fill_random(280);
    fill_phase = 1;
    put_cfg(3'd7);
    fill_random(500);
    fill_phase = 2;
    put_cfg(3'd0);
    fill_random(600);
    put_cfg(3'($urandom_range(2, 6)));
    fill_random(720);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || push || tag_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_bad == 0 && tag_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    feed_item_t head;
    logic nxt_push;
    logic do_cfg;
    if (rst) begin
      push <= 1'b0;
      cfg_wr <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (push && !full) tag_q.insert(tag_q.size(), tag_next_byte(data_byte));
      quiet_cycles <= (tag_q.size() == 0 && !push) ? quiet_cycles + 1 : 0;
      nxt_push = push && full;
      do_cfg = 1'b0;
      if (!nxt_push && byte_feed.size() != 0) begin
        head = byte_feed[0];
        if (head.is_cfg) begin
          // write only once the pipe has drained and settled
          if (tag_q.size() == 0 && !push && quiet_cycles >= 4) begin
            do_cfg = 1'b1;
            cfg_data <= head.value[2:0];
            dig_limit = head.value[2:0];
            void'(byte_feed.pop_front());
          end
        end else begin
          pop_stall_pct <= recv_stall[head.phase];
          if ($urandom_range(99) >= send_idle[head.phase]) begin
            nxt_push = 1'b1;
            data_byte <= head.value;
            void'(byte_feed.pop_front());
          end
        end
      end
      push <= nxt_push;
      cfg_wr <= do_cfg;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    result_beat_t want;
    logic bad;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tag_q.size() == 0) begin
          note_failure($sformatf("unexpected result beat: byte %02h tag %0d",
                                 echo_byte, field_tag));
        end else begin
          want = tag_q.pop_front();
          bad = echo_byte !== want.echo || field_tag !== want.tag ||
                field_start !== want.start || param_index !== want.pidx ||
                error_code !== want.err || end_of_message !== want.eom;
          if (bad)
            note_failure($sformatf({"tag mismatch: exp byte %02h tag %0d start %0b idx %0d ",
                                    "err %0d eom %0b, got byte %02h tag %0d start %0b ",
                                    "idx %0d err %0d eom %0b"},
                                   want.echo, want.tag, want.start, want.pidx, want.err,
                                   want.eom, echo_byte, field_tag, field_start,
                                   param_index, error_code, end_of_message));
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

endmodule
